@@ design/barycentric_weights_2d_core_macros.svh @@
// Assertion macros for the barycentric weights core checker.
// Uses the clk and rst_n names of the module that expands them.
`ifndef BARYCENTRIC_WEIGHTS_2D_CORE_MACROS_SVH
`define BARYCENTRIC_WEIGHTS_2D_CORE_MACROS_SVH

// same-cycle implication
`define BWC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bwc_pkg.sv @@
// Widths, constants and types for the barycentric weights core.
// No dependencies.
package bwc_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int EDGE_W   = PROD_W + 1;
    localparam int WFRAC    = 16;
    localparam int WEIGHT_W = 20;
    localparam int THR_W    = 47;
    localparam int QUO_W    = WEIGHT_W;
    localparam int DEN_W    = EDGE_W + 1;
    localparam int NUM_W    = EDGE_W + WFRAC + 2;
    localparam int REM_W    = DEN_W + QUO_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1 << WFRAC);
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MONE = -WEIGHT_ONE;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX  = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN  = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_t;

endpackage

@@ design/barycentric_weights_2d_core.sv @@
// Barycentric weights of a sample point in a 2D triangle, fully pipelined.
// Depends on bwc_pkg.
//
//  channel | signals                                    | direction
//  in      | in_valid, in_ready, pixel_*, vert*_*       | into core
//  out     | out_valid, out_ready, weight_*, degenerate | out of core
//  cfg     | cfg_we, cfg_wdata                          | into core
//
// One item per cycle while the output is not stalled; stages: differences, products, edge sums,
// magnitudes, dividend set-up, 20 restoring divide steps, saturate, gamma.
// The pipeline advances as a whole whenever the output stage is empty or taken.
// Reset clears valid bits and sets the threshold to one.
module barycentric_weights_2d_core
    import bwc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [THR_W-1:0]            cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   pixel_x,
    input  logic signed [COORD_W-1:0]   pixel_y,
    input  logic signed [COORD_W-1:0]   vert0_x,
    input  logic signed [COORD_W-1:0]   vert0_y,
    input  logic signed [COORD_W-1:0]   vert1_x,
    input  logic signed [COORD_W-1:0]   vert1_y,
    input  logic signed [COORD_W-1:0]   vert2_x,
    input  logic signed [COORD_W-1:0]   vert2_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WEIGHT_W-1:0]  weight_alpha,
    output logic signed [WEIGHT_W-1:0]  weight_beta,
    output logic signed [WEIGHT_W-1:0]  weight_gamma,
    output logic                        degenerate
);

    localparam int ST_ND  = 4;
    localparam int ST_SAT = ST_ND + QUO_W + 1;
    localparam int ST_OUT = ST_SAT + 1;
    localparam int N_ST   = ST_OUT + 1;

    logic [THR_W-1:0] thr_reg;
    logic [N_ST-1:0]  vld_reg;
    logic             advance;

    logic signed [DIFF_W-1:0] dif_reg [12];
    logic signed [PROD_W-1:0] prd_reg [8];
    logic signed [EDGE_W-1:0] edg_reg [4];
    logic [EDGE_W-1:0]        mag_reg [4];
    logic [3:0]               sgn_reg;
    logic [THR_W-1:0]         thr_d_reg;

    div_t      diva_reg [QUO_W+1];
    div_t      divb_reg [QUO_W+1];
    div_t      diva_next [QUO_W+1];
    div_t      divb_next [QUO_W+1];
    logic [QUO_W:0] dgn_reg;
    logic           dgn_next;

    logic signed [WEIGHT_W-1:0] sa_reg;
    logic signed [WEIGHT_W-1:0] sb_reg;
    logic                       sdgn_reg;

    logic signed [WEIGHT_W-1:0] alpha_reg;
    logic signed [WEIGHT_W-1:0] beta_reg;
    logic signed [WEIGHT_W-1:0] gamma_reg;
    logic                       dgn_out_reg;

    logic signed [WEIGHT_W+1:0] gamma_sum;
    logic signed [WEIGHT_W-1:0] gamma_next;

    function automatic logic signed [DIFF_W-1:0] sub_c(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic signed [EDGE_W-1:0] edge_sum(
        input logic signed [PROD_W-1:0] pos,
        input logic signed [PROD_W-1:0] neg
    );
        return {pos[PROD_W-1], pos} - {neg[PROD_W-1], neg};
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] sat_w(input div_t l);
        logic [QUO_W:0] negq;
        logic signed [WEIGHT_W-1:0] r;
        negq = -{1'b0, l.quo};
        if (!l.neg) begin
            r = (l.ovf || l.quo[QUO_W-1]) ? WEIGHT_MAX : l.quo;
        end else begin
            r = (l.ovf || (l.quo > {1'b1, {(QUO_W-1){1'b0}}})) ? WEIGHT_MIN
                                                                  : negq[QUO_W-1:0];
        end
        return r;
    endfunction

    assign advance   = !vld_reg[N_ST-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[N_ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (advance)
            begin
                vld_reg <= {vld_reg[N_ST-2:0], in_valid};
            end
        end
    end

    // divide steps: bit QUO_W-1-k in step k, overflow check in step 0
    always_comb
    begin
        diva_next[0] = diva_reg[0];
        divb_next[0] = divb_reg[0];
        for (int k = 0; k < QUO_W; k++)
        begin
            diva_next[k+1] = diva_reg[k];
            divb_next[k+1] = divb_reg[k];
            if (k == 0)
            begin
                diva_next[1].ovf = diva_reg[0].rem >= (REM_W'(diva_reg[0].den) << QUO_W);
                divb_next[1].ovf = divb_reg[0].rem >= (REM_W'(divb_reg[0].den) << QUO_W);
            end
            if (diva_reg[k].rem >= (REM_W'(diva_reg[k].den) << (QUO_W-1-k)))
            begin
                diva_next[k+1].rem = diva_reg[k].rem - (REM_W'(diva_reg[k].den) << (QUO_W-1-k));
                diva_next[k+1].quo[QUO_W-1-k] = 1'b1;
            end
            if (divb_reg[k].rem >= (REM_W'(divb_reg[k].den) << (QUO_W-1-k)))
            begin
                divb_next[k+1].rem = divb_reg[k].rem - (REM_W'(divb_reg[k].den) << (QUO_W-1-k));
                divb_next[k+1].quo[QUO_W-1-k] = 1'b1;
            end
        end
    end

    assign dgn_next = (mag_reg[0] < EDGE_W'(thr_d_reg)) || (mag_reg[1] < EDGE_W'(thr_d_reg))
                   || (mag_reg[0] == '0) || (mag_reg[1] == '0);

    assign gamma_sum = 22'(WEIGHT_ONE) - 22'(sa_reg) - 22'(sb_reg);
    assign gamma_next = (gamma_sum > 22'(WEIGHT_MAX)) ? WEIGHT_MAX :
                        (gamma_sum < 22'(WEIGHT_MIN)) ? WEIGHT_MIN :
                        gamma_sum[WEIGHT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dif_reg[0]  <= sub_c(vert0_x, vert1_x);
            dif_reg[1]  <= sub_c(vert2_y, vert1_y);
            dif_reg[2]  <= sub_c(vert0_y, vert1_y);
            dif_reg[3]  <= sub_c(vert2_x, vert1_x);
            dif_reg[4]  <= sub_c(vert1_x, vert2_x);
            dif_reg[5]  <= sub_c(vert0_y, vert2_y);
            dif_reg[6]  <= sub_c(vert1_y, vert2_y);
            dif_reg[7]  <= sub_c(vert0_x, vert2_x);
            dif_reg[8]  <= sub_c(pixel_x, vert1_x);
            dif_reg[9]  <= sub_c(pixel_y, vert1_y);
            dif_reg[10] <= sub_c(pixel_x, vert2_x);
            dif_reg[11] <= sub_c(pixel_y, vert2_y);

            prd_reg[0] <= dif_reg[0]  * dif_reg[1];
            prd_reg[1] <= dif_reg[2]  * dif_reg[3];
            prd_reg[2] <= dif_reg[4]  * dif_reg[5];
            prd_reg[3] <= dif_reg[6]  * dif_reg[7];
            prd_reg[4] <= dif_reg[8]  * dif_reg[1];
            prd_reg[5] <= dif_reg[9]  * dif_reg[3];
            prd_reg[6] <= dif_reg[10] * dif_reg[5];
            prd_reg[7] <= dif_reg[11] * dif_reg[7];

            // alpha den, beta den, alpha num, beta num
            edg_reg[0] <= edge_sum(prd_reg[1], prd_reg[0]);
            edg_reg[1] <= edge_sum(prd_reg[3], prd_reg[2]);
            edg_reg[2] <= edge_sum(prd_reg[5], prd_reg[4]);
            edg_reg[3] <= edge_sum(prd_reg[7], prd_reg[6]);

            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= edg_reg[i][EDGE_W-1] ? -edg_reg[i] : edg_reg[i];
                sgn_reg[i] <= edg_reg[i][EDGE_W-1];
            end
            thr_d_reg <= thr_reg;

            diva_reg[0].rem <= (REM_W'(mag_reg[2]) << (WFRAC + 1)) + REM_W'(mag_reg[0]);
            diva_reg[0].den <= {mag_reg[0], 1'b0};
            diva_reg[0].quo <= '0;
            diva_reg[0].neg <= sgn_reg[2] ^ sgn_reg[0];
            diva_reg[0].ovf <= 1'b0;
            divb_reg[0].rem <= (REM_W'(mag_reg[3]) << (WFRAC + 1)) + REM_W'(mag_reg[1]);
            divb_reg[0].den <= {mag_reg[1], 1'b0};
            divb_reg[0].quo <= '0;
            divb_reg[0].neg <= sgn_reg[3] ^ sgn_reg[1];
            divb_reg[0].ovf <= 1'b0;
            dgn_reg[0]      <= dgn_next;

            for (int k = 1; k <= QUO_W; k++)
            begin
                diva_reg[k] <= diva_next[k];
                divb_reg[k] <= divb_next[k];
                dgn_reg[k]  <= dgn_reg[k-1];
            end

            sa_reg   <= sat_w(diva_reg[QUO_W]);
            sb_reg   <= sat_w(divb_reg[QUO_W]);
            sdgn_reg <= dgn_reg[QUO_W];

            alpha_reg   <= sdgn_reg ? WEIGHT_MONE : sa_reg;
            beta_reg    <= sdgn_reg ? WEIGHT_MONE : sb_reg;
            gamma_reg   <= sdgn_reg ? WEIGHT_MONE : gamma_next;
            dgn_out_reg <= sdgn_reg;
        end
    end

    assign weight_alpha = alpha_reg;
    assign weight_beta  = beta_reg;
    assign weight_gamma = gamma_reg;
    assign degenerate   = dgn_out_reg;

endmodule

@@ design/bwc_checker.sv @@
// Port-level checker for the barycentric weights core, bound to the top level.
// Depends on bwc_pkg and barycentric_weights_2d_core_macros.svh.
`include "barycentric_weights_2d_core_macros.svh"

module bwc_checker
    import bwc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [WEIGHT_W-1:0] weight_alpha,
    input logic signed [WEIGHT_W-1:0] weight_beta,
    input logic signed [WEIGHT_W-1:0] weight_gamma,
    input logic                       degenerate
);

    `BWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out item dropped while stalled")
    `BWC_ASSERT_IMPL(a_stall_back, out_valid && !out_ready, !in_ready, "input taken during output stall")
    `BWC_ASSERT_IMPL(a_degen_wts, out_valid && degenerate, (weight_alpha == WEIGHT_MONE) && (weight_beta == WEIGHT_MONE) && (weight_gamma == WEIGHT_MONE), "degenerate item without minus-one weights")

endmodule

bind barycentric_weights_2d_core bwc_checker u_bwc_checker (.*);
